FILE: rtl/rlsg_pkg.sv
// Shared types and constants for the random Latin square generator.
// Used by rlsg_mod and the generator top; depends on nothing.

package rlsg_pkg;

    localparam int DEF_MAX_ORDER = 32;

    localparam int CMD_W      = 2;
    localparam int WORD_W     = 31;
    localparam int ROW_W      = 5;
    localparam int CFG_W      = 6;
    localparam int OUT_W      = 6;
    localparam int IN_TDATA_W = 40;   // word + row, padded to whole bytes
    localparam int OUT_TDATA_W = 8;   // cell value, padded to whole bytes

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROW   = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_RDA,
        S_RDB,
        S_RDW,
        S_WR2,
        S_C0,
        S_C1,
        S_C2,
        S_C3,
        S_EMIT,
        S_ERR
    } t_state;

endpackage

FILE: rtl/rlsg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.

module rlsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rlsg_mod.sv
// Iterative modulo unit: reduces a random word by a small divisor,
// one dividend bit per cycle (restoring). Depends on rlsg_pkg.

module rlsg_mod #(
    parameter int MAX_ORDER = rlsg_pkg::DEF_MAX_ORDER
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rlsg_pkg::WORD_W-1:0]   i_dividend,
    input  logic [$clog2(MAX_ORDER+1)-1:0] i_divisor,
    output logic                          o_done,
    output logic [$clog2(MAX_ORDER)-1:0]  o_rem
);

    import rlsg_pkg::*;

    localparam int PW = $clog2(MAX_ORDER + 1);
    localparam int AW = $clog2(MAX_ORDER);
    localparam int SW = $clog2(WORD_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [SW-1:0]     r_cnt, n_cnt;
    logic [WORD_W-1:0] r_word, n_word;
    logic [PW-1:0]     r_rem, n_rem;
    logic [PW:0]       w_trial;

    assign w_trial = {r_rem, r_word[WORD_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_word = r_word;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = SW'(WORD_W - 1);
            n_word = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_word = {r_word[WORD_W-2:0], 1'b0};
            if (w_trial >= {1'b0, i_divisor}) begin
                n_rem = PW'(w_trial - {1'b0, i_divisor});
            end else begin
                n_rem = PW'(w_trial);
            end
            n_cnt = r_cnt - SW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_word <= n_word;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = AW'(r_rem);

    // The partial remainder never reaches the divisor, so it fits an address.
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |-> (r_rem < i_divisor))
        else $error("partial remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("modulo done without a running division");

endmodule

FILE: rtl/random_latin_square_generator.sv
// Random Latin square generator: keeps a shuffled permutation in RAM and
// emits rows of the square. A start request reloads the identity, one RAM
// entry per cycle; the same pass runs after reset before the first request is
// taken. A draw request, which does nothing unless at least two entries remain
// to shuffle, runs a modulo in the division unit and then swaps two entries.
// A row request walks the columns through three dependent reads of the
// permutation and its inverse for each cell, and waits while the output stalls.
// A bad row index yields one error cell. s_axis_tready is high only while the
// sequencer is idle.
// Depends on rlsg_pkg, rlsg_ram and rlsg_mod.

module random_latin_square_generator #(
    parameter int MAX_ORDER = rlsg_pkg::DEF_MAX_ORDER
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: square order
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rlsg_pkg::CFG_W-1:0]        i_cfg_data,
    // Requests
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rlsg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // random_word[30:0], row_index[35:31]
    input  logic [rlsg_pkg::CMD_W-1:0]        s_axis_tuser,  // command[1:0]
    // Cells
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rlsg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // cell_value[5:0]
    output logic                              m_axis_tuser,  // row_error[0]
    output logic                              m_axis_tlast   // last_cell
);

    import rlsg_pkg::*;

    localparam int PW = $clog2(MAX_ORDER + 1);
    localparam int AW = $clog2(MAX_ORDER);
    localparam int OW = (PW > CFG_W) ? PW : CFG_W;
    localparam int CW = (PW > ROW_W) ? PW : ROW_W;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_order;
    logic [PW-1:0]     r_bound, n_bound;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_idx, n_idx;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [PW-1:0]     r_va, n_va;
    logic [PW-1:0]     r_val, n_val;

    logic              r_m_valid, n_m_valid;
    logic [OUT_W-1:0]  r_m_cell, n_m_cell;
    logic              r_m_err, n_m_err;
    logic              r_m_last, n_m_last;

    logic              p_we;
    logic [AW-1:0]     p_waddr, p_raddr;
    logic [PW-1:0]     p_wdata, p_rdata;
    logic              q_we;
    logic [AW-1:0]     q_waddr, q_raddr, q_wdata, q_rdata;

    logic              mod_start, mod_done;
    logic [AW-1:0]     mod_rem;

    logic              w_accept, w_out_free, w_armed;
    logic [CMD_W-1:0]  w_cmd;
    logic [WORD_W-1:0] w_word;
    logic [ROW_W-1:0]  w_row_in;
    logic [OW-1:0]     w_order_ext;
    logic [PW-1:0]     w_n;
    logic [CW-1:0]     w_n_ext, w_k_ext, w_row_ext, w_i;
    logic [AW-1:0]     w_last_addr;
    logic [OUT_W+PW-1:0] w_val_wide;

    assign w_cmd    = s_axis_tuser;
    assign w_word   = s_axis_tdata[WORD_W-1:0];
    assign w_row_in = s_axis_tdata[WORD_W+ROW_W-1:WORD_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Effective order: zero acts as one, anything above the maximum is clamped.
    assign w_order_ext = OW'(r_order);
    always_comb begin
        if (w_order_ext == '0) begin
            w_n = PW'(1);
        end else if (w_order_ext > OW'(MAX_ORDER)) begin
            w_n = PW'(MAX_ORDER);
        end else begin
            w_n = PW'(w_order_ext);
        end
    end

    assign w_armed     = (r_bound >= PW'(2));
    assign w_n_ext     = CW'(w_n);
    assign w_k_ext     = CW'(q_rdata);
    assign w_row_ext   = CW'(r_row);
    assign w_last_addr = AW'(r_bound - PW'(1));

    // Position in the shifted row; wraps modulo the order.
    assign w_i = (w_k_ext >= w_row_ext) ? (w_k_ext - w_row_ext)
                                        : (w_k_ext + w_n_ext - w_row_ext);

    assign w_val_wide = {{OUT_W{1'b0}}, r_val};

    always_comb begin
        n_state   = r_state;
        n_bound   = r_bound;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_row     = r_row;
        n_va      = r_va;
        n_val     = r_val;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_cell  = r_m_cell;
        n_m_err   = r_m_err;
        n_m_last  = r_m_last;
        p_we      = 1'b0;
        p_waddr   = r_cnt;
        p_wdata   = PW'(r_cnt) + PW'(1);
        p_raddr   = '0;
        q_we      = 1'b0;
        q_waddr   = r_cnt;
        q_wdata   = r_cnt;
        q_raddr   = r_cnt;
        mod_start = 1'b0;

        case (r_state)
            S_INIT: begin
                // Identity pass over the permutation and its inverse.
                p_we  = 1'b1;
                q_we  = 1'b1;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(MAX_ORDER - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (w_cmd)
                        CMD_START: begin
                            n_bound = w_n;
                            n_cnt   = '0;
                            n_state = S_INIT;
                        end
                        CMD_DRAW: begin
                            if (w_armed) begin
                                mod_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        CMD_ROW: begin
                            n_row = w_row_in;
                            n_cnt = '0;
                            if (CW'(w_row_in) >= w_n_ext) begin
                                n_state = S_ERR;
                            end else begin
                                n_state = S_C0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (mod_done) begin
                    n_idx   = mod_rem;
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                p_raddr = r_idx;
                n_state = S_RDB;
            end
            S_RDB: begin
                p_raddr = w_last_addr;
                n_va    = p_rdata;
                n_state = S_RDW;
            end
            S_RDW: begin
                // The entry at the top of the range moves down to the drawn index.
                p_we    = 1'b1;
                p_waddr = r_idx;
                p_wdata = p_rdata;
                q_we    = 1'b1;
                q_waddr = AW'(p_rdata - PW'(1));
                q_wdata = r_idx;
                n_state = S_WR2;
            end
            S_WR2: begin
                p_we    = 1'b1;
                p_waddr = w_last_addr;
                p_wdata = r_va;
                q_we    = 1'b1;
                q_waddr = AW'(r_va - PW'(1));
                q_wdata = w_last_addr;
                n_bound = r_bound - PW'(1);
                n_state = S_IDLE;
            end
            S_C0: begin
                q_raddr = r_cnt;
                n_state = S_C1;
            end
            S_C1: begin
                // A symbol that sits beyond the current order gives an empty cell.
                if (w_k_ext < w_n_ext) begin
                    p_raddr = AW'(w_i);
                    n_state = S_C2;
                end else begin
                    n_val   = '0;
                    n_state = S_EMIT;
                end
            end
            S_C2: begin
                p_raddr = AW'(p_rdata - PW'(1));
                n_state = S_C3;
            end
            S_C3: begin
                n_val   = p_rdata;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_cell  = w_val_wide[OUT_W-1:0];
                    n_m_err   = 1'b0;
                    n_m_last  = (PW'(r_cnt) == w_n - PW'(1));
                    if (PW'(r_cnt) == w_n - PW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + AW'(1);
                        n_state = S_C0;
                    end
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_cell  = '0;
                    n_m_err   = 1'b1;
                    n_m_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_order   <= CFG_W'(1);
            r_bound   <= '0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bound   <= n_bound;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_order <= i_cfg_data;
            end
        end
        r_idx    <= n_idx;
        r_row    <= n_row;
        r_va     <= n_va;
        r_val    <= n_val;
        r_m_cell <= n_m_cell;
        r_m_err  <= n_m_err;
        r_m_last <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_m_cell);
    assign m_axis_tuser  = r_m_err;
    assign m_axis_tlast  = r_m_last;

    rlsg_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_ORDER)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    rlsg_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_ORDER)
    ) u_inv (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    rlsg_mod #(
        .MAX_ORDER (MAX_ORDER)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (w_word),
        .i_divisor  (r_bound),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    a_bound_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bound <= PW'(MAX_ORDER))
        else $error("draw bound above maximum order");

    a_err_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("error cell must be empty and last");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) &&
                                               $stable(m_axis_tuser) && $stable(m_axis_tlast)))
        else $error("waiting cell changed before it was taken");

endmodule
